>>> rtl/agv_pkg.sv
// shared types and constants for the arrow glyph vertex generator
// no dependencies
package agv_pkg;

    localparam logic [15:0] HEAD_SCALE_RESET = 16'd6554;
    localparam logic [2:0]  ADDR_HEAD_SCALE  = 3'd0;
    localparam logic [3:0]  VTX_LAST         = 4'd9;

    // one segment as it enters
    typedef struct packed {
        logic [2:0][31:0] st;
        logic [2:0][31:0] en;
        logic             final_segment;
    } seg_t;

    // one finished arrow, ready for vertex output
    typedef struct packed {
        logic [2:0][31:0] st;
        logic [2:0][31:0] en;
        logic [2:0][34:0] base;
        logic [2:0][33:0] toff;
        logic [2:0][33:0] boff;
        logic             final_segment;
    } head_t;

endpackage

>>> rtl/arrow_glyph_vertex_generator_top.sv
// arrow glyph vertex generator: one segment in, ten line-list vertices out
// time from segment accept to first vertex is set by the normalize shifts, and is shorter
// for zero length, which skips the root and divide steps
// the geometry engine takes one segment at a time, its time set by the 28-step root
// and 30-step dividers; vertices leave one per cycle while m_ready is high, ten per segment
// reset: synchronous active low, empties both queues and sets head_scale to 6554
module arrow_glyph_vertex_generator_top import agv_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_start_x,
    input  logic [31:0] s_start_y,
    input  logic [31:0] s_start_z,
    input  logic [31:0] s_end_x,
    input  logic [31:0] s_end_y,
    input  logic [31:0] s_end_z,
    input  logic        s_final_segment,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_vertex_x,
    output logic [31:0] m_vertex_y,
    output logic [31:0] m_vertex_z,
    output logic [3:0]  m_vertex_number,
    output logic        m_arrow_done,
    output logic        m_batch_done
);
    logic [15:0] head_scale_reg;
    seg_t        s_seg, q_seg;
    head_t       g_item, e_item;
    logic        q_valid, q_pop;
    logic        g_push, g_ready;
    logic        e_valid, e_pop;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_HEAD_SCALE) ? 32'(head_scale_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_scale_reg <= HEAD_SCALE_RESET;
        end else if (psel && penable && pwrite && (paddr == ADDR_HEAD_SCALE)) begin
            head_scale_reg <= pwdata[15:0];
        end
    end

    assign s_seg.st            = {s_start_z, s_start_y, s_start_x};
    assign s_seg.en            = {s_end_z, s_end_y, s_end_x};
    assign s_seg.final_segment = s_final_segment;

    agv_fifo #(.W($bits(seg_t)), .DEPTH(QUEUE_DEPTH)) u_in_q (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (s_valid),
        .wr_ready (s_ready),
        .wr_data  (s_seg),
        .rd_valid (q_valid),
        .rd_ready (q_pop),
        .rd_data  (q_seg)
    );

    agv_geom u_geom (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_scale (head_scale_reg),
        .in_valid   (q_valid),
        .in_item    (q_seg),
        .in_pop     (q_pop),
        .out_push   (g_push),
        .out_item   (g_item),
        .out_full   (!g_ready)
    );

    agv_fifo #(.W($bits(head_t)), .DEPTH(QUEUE_DEPTH)) u_mid_q (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (g_push),
        .wr_ready (g_ready),
        .wr_data  (g_item),
        .rd_valid (e_valid),
        .rd_ready (e_pop),
        .rd_data  (e_item)
    );

    agv_emit u_emit (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .item_valid      (e_valid),
        .item            (e_item),
        .item_pop        (e_pop),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_vertex_x      (m_vertex_x),
        .m_vertex_y      (m_vertex_y),
        .m_vertex_z      (m_vertex_z),
        .m_vertex_number (m_vertex_number),
        .m_arrow_done    (m_arrow_done),
        .m_batch_done    (m_batch_done)
    );
endmodule

>>> rtl/agv_fifo.sv
// small register fifo between pipeline parts
// no dependencies
module agv_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         wr_valid,
    output logic         wr_ready,
    input  logic [W-1:0] wr_data,
    output logic         rd_valid,
    input  logic         rd_ready,
    output logic [W-1:0] rd_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr, do_rd;

    assign wr_ready = (count_reg != CW'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = mem_reg[rd_ptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end
endmodule

>>> rtl/agv_geom.sv
// arrow geometry engine: direction, basis, roots, quotients and head offsets
// uses agv_pkg; one shared multiplier, bit-serial roots and dividers
module agv_geom import agv_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] head_scale,
    input  logic        in_valid,
    input  seg_t        in_item,
    output logic        in_pop,
    output logic        out_push,
    output head_t       out_item,
    input  logic        out_full
);
    typedef enum logic [12:0] {
        G_IDLE    = 13'b0000000000001,
        G_PREP    = 13'b0000000000010,
        G_ALONG   = 13'b0000000000100,
        G_NORM    = 13'b0000000001000,
        G_SQUARE  = 13'b0000000010000,
        G_TEST    = 13'b0000000100000,
        G_SQRT    = 13'b0000001000000,
        G_NUMER   = 13'b0000010000000,
        G_DIVINIT = 13'b0000100000000,
        G_DIV     = 13'b0001000000000,
        G_OFFSET  = 13'b0010000000000,
        G_ROUND   = 13'b0100000000000,
        G_PUSH    = 13'b1000000000000
    } gstate_t;

    typedef struct packed {
        logic [55:0] x;
        logic [55:0] r;
    } root_t;

    localparam logic [4:0] LAST_AXIS  = 5'd2;
    localparam logic [4:0] LAST_ROOT  = 5'd27;
    localparam logic [4:0] LAST_NUMER = 5'd3;
    localparam logic [4:0] LAST_DIV   = 5'd29;
    localparam logic [4:0] LAST_OFF   = 5'd5;

    function automatic root_t root_step(input logic [55:0] x, input logic [55:0] r,
                                        input logic [55:0] b);
        logic [56:0] t;
        root_t       o;
        t = {1'b0, r} + {1'b0, b};
        if ({1'b0, x} >= t) begin
            o.x = x - t[55:0];
            o.r = (r >> 1) + b;
        end else begin
            o.x = x;
            o.r = r >> 1;
        end
        return o;
    endfunction

    gstate_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    seg_t               seg_reg;
    logic signed [32:0] d_reg [3];
    logic [32:0]        g_reg [3];
    logic [32:0]        m_reg;
    logic               zero_reg;
    logic signed [5:0]  ex_reg;
    logic signed [49:0] along_raw_reg [3];
    logic [53:0]        sq_reg [3];
    logic               zb_reg;
    logic [55:0]        lx_reg, rx_reg, lr_reg, rr_reg, bit_reg;
    logic signed [56:0] num_reg [4];
    logic               qneg_reg [4];
    logic [57:0]        rem_reg [4];
    logic [57:0]        dv_reg;
    logic [29:0]        quo_reg [4];
    logic signed [47:0] off_raw_reg [6];
    logic signed [33:0] along_reg [3];
    logic signed [33:0] toff_reg [3];
    logic signed [33:0] boff_reg [3];

    logic signed [27:0] qv [3];
    logic signed [30:0] qs [4];
    logic signed [30:0] vec [6];
    logic signed [30:0] r_s;
    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;
    logic [1:0]         idx2;
    logic [2:0]         idx3;
    logic               norm_done;
    logic               neg_sel;
    logic [5:0]         off_sh;
    root_t              l_step, r_step;

    assign idx2      = cnt_reg[1:0];
    assign idx3      = cnt_reg[2:0];
    assign norm_done = (m_reg[32:27] == '0) && m_reg[26];
    assign off_sh    = 6'($signed({ex_reg[5], ex_reg}) + 7'sd17);
    assign l_step    = root_step(lx_reg, lr_reg, bit_reg);
    assign r_step    = root_step(rx_reg, rr_reg, bit_reg);
    assign r_s       = $signed({2'b0, rr_reg[28:0]});

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            qv[i] = d_reg[i][32] ? -$signed({1'b0, g_reg[i][26:0]})
                                 : $signed({1'b0, g_reg[i][26:0]});
        end
        for (int j = 0; j < 4; j++) begin
            qs[j] = qneg_reg[j] ? -$signed({1'b0, quo_reg[j]}) : $signed({1'b0, quo_reg[j]});
        end
        // tangent in 0..2, bitangent in 3..5
        if (zb_reg) begin
            vec[0] = qs[2]; vec[1] = qs[3]; vec[2] = r_s;
            vec[3] = qs[0]; vec[4] = qs[1]; vec[5] = '0;
        end else begin
            vec[0] = qs[2]; vec[1] = r_s;   vec[2] = qs[3];
            vec[3] = qs[0]; vec[4] = '0;    vec[5] = qs[1];
        end
    end

    // shared multiplier operand select
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        neg_sel = 1'b0;
        unique case (state_reg)
            G_ALONG: begin
                mul_a = 34'(d_reg[idx2]);
                mul_b = 34'(head_scale);
            end
            G_SQUARE: begin
                mul_a = 34'(qv[idx2]);
                mul_b = 34'(qv[idx2]);
            end
            G_NUMER: begin
                unique case (idx2)
                    2'd0: begin
                        mul_a   = 34'(lr_reg[28:0]);
                        mul_b   = zb_reg ? 34'(qv[1]) : 34'(qv[2]);
                        neg_sel = !zb_reg;
                    end
                    2'd1: begin
                        mul_a   = 34'(lr_reg[28:0]);
                        mul_b   = 34'(qv[0]);
                        neg_sel = zb_reg;
                    end
                    2'd2: begin
                        mul_a   = 34'(qv[0]);
                        mul_b   = zb_reg ? 34'(qv[2]) : 34'(qv[1]);
                        neg_sel = 1'b1;
                    end
                    default: begin
                        mul_a   = zb_reg ? 34'(qv[1]) : 34'(qv[2]);
                        mul_b   = zb_reg ? 34'(qv[2]) : 34'(qv[1]);
                        neg_sel = 1'b1;
                    end
                endcase
            end
            G_OFFSET: begin
                mul_a = (idx3 < 3'd6) ? 34'(vec[idx3]) : '0;
                mul_b = 34'(head_scale);
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            G_IDLE:    if (in_valid) state_next = G_PREP;
            G_PREP: begin
                state_next = G_ALONG;
                cnt_next   = '0;
            end
            G_ALONG: begin
                if (cnt_reg == LAST_AXIS) begin
                    state_next = G_NORM;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            G_NORM: begin
                if (zero_reg) begin
                    state_next = G_ROUND;
                end else if (norm_done) begin
                    state_next = G_SQUARE;
                    cnt_next   = '0;
                end
            end
            G_SQUARE: begin
                if (cnt_reg == LAST_AXIS) begin
                    state_next = G_TEST;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            G_TEST: begin
                state_next = G_SQRT;
                cnt_next   = '0;
            end
            G_SQRT: begin
                if (cnt_reg == LAST_ROOT) begin
                    state_next = G_NUMER;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            G_NUMER: begin
                if (cnt_reg == LAST_NUMER) begin
                    state_next = G_DIVINIT;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            G_DIVINIT: begin
                state_next = G_DIV;
                cnt_next   = '0;
            end
            G_DIV: begin
                if (cnt_reg == LAST_DIV) begin
                    state_next = G_OFFSET;
                    cnt_next   = '0;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            G_OFFSET: begin
                if (cnt_reg == LAST_OFF) begin
                    state_next = G_ROUND;
                end else begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            G_ROUND:   state_next = G_PUSH;
            G_PUSH:    if (!out_full) state_next = G_IDLE;
            default:   state_next = G_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= G_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        logic [49:0]        amag;
        logic [50:0]        asum;
        logic [34:0]        aq;
        logic [47:0]        omag;
        logic [48:0]        osum;
        logic [48:0]        oq;
        logic [33:0]        ov [6];
        logic [56:0]        nmag;
        logic [63:0]        lhs, rhs;
        unique case (state_reg)
            G_IDLE: begin
                if (in_valid) begin
                    seg_reg <= in_item;
                    for (int i = 0; i < 3; i++) begin
                        d_reg[i] <= 33'($signed(in_item.en[i])) - 33'($signed(in_item.st[i]));
                    end
                end
            end
            G_PREP: begin
                logic [32:0] g0, g1, g2, mx;
                g0 = d_reg[0][32] ? 33'(-d_reg[0]) : 33'(d_reg[0]);
                g1 = d_reg[1][32] ? 33'(-d_reg[1]) : 33'(d_reg[1]);
                g2 = d_reg[2][32] ? 33'(-d_reg[2]) : 33'(d_reg[2]);
                mx = (g0 > g1) ? g0 : g1;
                mx = (g2 > mx) ? g2 : mx;
                g_reg[0] <= g0;
                g_reg[1] <= g1;
                g_reg[2] <= g2;
                m_reg    <= mx;
                zero_reg <= (mx == '0);
                ex_reg   <= '0;
            end
            G_ALONG: begin
                along_raw_reg[idx2] <= prod[49:0];
            end
            G_NORM: begin
                if (!zero_reg) begin
                    priority if (m_reg[32:27] != '0) begin
                        for (int i = 0; i < 3; i++) g_reg[i] <= g_reg[i] >> 1;
                        m_reg  <= m_reg >> 1;
                        ex_reg <= ex_reg - 6'sd1;
                    end else if (m_reg[32:18] == '0) begin
                        for (int i = 0; i < 3; i++) g_reg[i] <= g_reg[i] << 8;
                        m_reg  <= m_reg << 8;
                        ex_reg <= ex_reg + 6'sd8;
                    end else if (m_reg[32:22] == '0) begin
                        for (int i = 0; i < 3; i++) g_reg[i] <= g_reg[i] << 4;
                        m_reg  <= m_reg << 4;
                        ex_reg <= ex_reg + 6'sd4;
                    end else if (!m_reg[26]) begin
                        for (int i = 0; i < 3; i++) g_reg[i] <= g_reg[i] << 1;
                        m_reg  <= m_reg << 1;
                        ex_reg <= ex_reg + 6'sd1;
                    end else begin
                    end
                end
            end
            G_SQUARE: begin
                sq_reg[idx2] <= prod[53:0];
            end
            G_TEST: begin
                lhs = 64'(sq_reg[1]) * 64'd39;
                rhs = (64'(sq_reg[0]) + 64'(sq_reg[2])) * 64'd361;
                zb_reg  <= (lhs >= rhs);
                lx_reg  <= 56'(sq_reg[0]) + 56'(sq_reg[1]) + 56'(sq_reg[2]);
                rx_reg  <= (lhs >= rhs) ? 56'(sq_reg[0]) + 56'(sq_reg[1])
                                        : 56'(sq_reg[0]) + 56'(sq_reg[2]);
                lr_reg  <= '0;
                rr_reg  <= '0;
                bit_reg <= 56'd1 << 54;
            end
            G_SQRT: begin
                lx_reg  <= l_step.x;
                lr_reg  <= l_step.r;
                rx_reg  <= r_step.x;
                rr_reg  <= r_step.r;
                bit_reg <= bit_reg >> 2;
            end
            G_NUMER: begin
                num_reg[idx2]  <= prod[56:0];
                qneg_reg[idx2] <= prod[67] ^ neg_sel;
            end
            G_DIVINIT: begin
                for (int j = 0; j < 4; j++) begin
                    nmag = num_reg[j][56] ? 57'(-num_reg[j]) : 57'(num_reg[j]);
                    rem_reg[j] <= {1'b0, nmag} + 58'(rr_reg[28:1]);
                    quo_reg[j] <= '0;
                end
                dv_reg <= {rr_reg[28:0], 29'b0};
            end
            G_DIV: begin
                for (int j = 0; j < 4; j++) begin
                    if (rem_reg[j] >= dv_reg) begin
                        rem_reg[j] <= rem_reg[j] - dv_reg;
                        quo_reg[j] <= {quo_reg[j][28:0], 1'b1};
                    end else begin
                        quo_reg[j] <= {quo_reg[j][28:0], 1'b0};
                    end
                end
                dv_reg <= dv_reg >> 1;
            end
            G_OFFSET: begin
                off_raw_reg[idx3] <= prod[47:0];
            end
            G_ROUND: begin
                for (int i = 0; i < 3; i++) begin
                    amag = along_raw_reg[i][49] ? 50'(-along_raw_reg[i]) : 50'(along_raw_reg[i]);
                    asum = {1'b0, amag} + 51'(16'h8000);
                    aq   = asum[50:16];
                    along_reg[i] <= along_raw_reg[i][49] ? 34'(-aq) : 34'(aq);
                end
                for (int k = 0; k < 6; k++) begin
                    omag = off_raw_reg[k][47] ? 48'(-off_raw_reg[k]) : 48'(off_raw_reg[k]);
                    osum = {1'b0, omag} + (49'd1 << (off_sh - 6'd1));
                    oq   = osum >> off_sh;
                    ov[k] = zero_reg ? '0
                          : (off_raw_reg[k][47] ? 34'(-oq) : 34'(oq));
                end
                for (int i = 0; i < 3; i++) begin
                    toff_reg[i] <= ov[i];
                    boff_reg[i] <= ov[i + 3];
                end
            end
            default: begin
            end
        endcase
    end

    assign in_pop   = (state_reg == G_IDLE) && in_valid;
    assign out_push = (state_reg == G_PUSH) && !out_full;

    always_comb begin
        out_item.st            = seg_reg.st;
        out_item.en            = seg_reg.en;
        out_item.final_segment = seg_reg.final_segment;
        for (int i = 0; i < 3; i++) begin
            out_item.base[i] = 35'($signed(seg_reg.en[i])) - 35'(along_reg[i]);
            out_item.toff[i] = toff_reg[i];
            out_item.boff[i] = boff_reg[i];
        end
    end
endmodule

>>> rtl/agv_emit.sv
// vertex emitter: walks the ten vertices of each arrow into the output register
// uses agv_pkg
module agv_emit import agv_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        item_valid,
    input  head_t       item,
    output logic        item_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_vertex_x,
    output logic [31:0] m_vertex_y,
    output logic [31:0] m_vertex_z,
    output logic [3:0]  m_vertex_number,
    output logic        m_arrow_done,
    output logic        m_batch_done
);
    function automatic logic [31:0] sat32(input logic signed [35:0] v);
        if (v > 36'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -36'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    logic [3:0]       k_reg, k_next;
    logic             valid_reg;
    logic [2:0][31:0] vtx_reg;
    logic [3:0]       num_reg;
    logic             adone_reg, bdone_reg;
    logic [2:0][31:0] vtx;
    logic             load;

    assign load     = item_valid && (!valid_reg || m_ready);
    assign item_pop = load && (k_reg == VTX_LAST);
    assign k_next   = (k_reg == VTX_LAST) ? '0 : k_reg + 1'b1;

    always_comb begin
        logic signed [35:0] b, t, o;
        for (int i = 0; i < 3; i++) begin
            b = 36'($signed(item.base[i]));
            t = 36'($signed(item.toff[i]));
            o = 36'($signed(item.boff[i]));
            unique case (k_reg)
                4'd0:    vtx[i] = item.st[i];
                4'd2:    vtx[i] = sat32(b - t);
                4'd4:    vtx[i] = sat32(b + t);
                4'd6:    vtx[i] = sat32(b - o);
                4'd8:    vtx[i] = sat32(b + o);
                default: vtx[i] = item.en[i];
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg     <= '0;
            valid_reg <= 1'b0;
        end else if (load) begin
            k_reg     <= k_next;
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            vtx_reg   <= vtx;
            num_reg   <= k_reg;
            adone_reg <= (k_reg == VTX_LAST);
            bdone_reg <= (k_reg == VTX_LAST) && item.final_segment;
        end
    end

    assign m_valid         = valid_reg;
    assign m_vertex_x      = vtx_reg[0];
    assign m_vertex_y      = vtx_reg[1];
    assign m_vertex_z      = vtx_reg[2];
    assign m_vertex_number = num_reg;
    assign m_arrow_done    = adone_reg;
    assign m_batch_done    = bdone_reg;
endmodule

>>> verif/arrow_glyph_vertex_generator_top_tb.sv
// testbench for arrow_glyph_vertex_generator_top: drives segments and head_scale writes,
// predicts the ten vertices of each arrow and checks them in order
// depends on rtl/agv_pkg.sv and rtl/arrow_glyph_vertex_generator_top.sv
module arrow_glyph_vertex_generator_top_tb import agv_pkg::*; ();

    localparam int LIMIT = 600000;
    localparam int SETTLE = 120;

    typedef struct packed {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [3:0]  num;
        logic        arrow_done;
        logic        batch_done;
    } vertex_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_start_x = '0, s_start_y = '0, s_start_z = '0;
    logic [31:0] s_end_x = '0, s_end_y = '0, s_end_z = '0;
    logic        s_final_segment = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_vertex_x, m_vertex_y, m_vertex_z;
    logic [3:0]  m_vertex_number;
    logic        m_arrow_done, m_batch_done;

    vertex_t     vertex_queue[$];
    logic [15:0] scale_shadow = HEAD_SCALE_RESET;
    int          errors = 0;
    int          cycles = 0;
    int          hold_left = 0;
    bit          tx_gaps = 1'b1;
    bit          rx_gaps = 1'b1;

    arrow_glyph_vertex_generator_top dut (.*);

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // receiver readiness, with long hold-off on request
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= !(rx_gaps && $urandom_range(99) < 20);
        end
    end

    always @(posedge aclk) begin
        vertex_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = {m_vertex_x, m_vertex_y, m_vertex_z, m_vertex_number,
                   m_arrow_done, m_batch_done};
            if (vertex_queue.size() == 0) begin
                errors++;
                if (errors <= 10) $display("unexpected vertex %h", got);
            end else begin
                want = vertex_queue.pop_front();
                if (got !== want) begin
                    errors++;
                    if (errors <= 10)
                        $display({"mismatch: expected x=%h y=%h z=%h n=%0d a=%b b=%b, ",
                                  "got x=%h y=%h z=%h n=%0d a=%b b=%b"},
                                 want.x, want.y, want.z, want.num, want.arrow_done,
                                 want.batch_done, got.x, got.y, got.z, got.num,
                                 got.arrow_done, got.batch_done);
                end
            end
        end
    end

    function automatic longint mag(longint v);
        return v < 0 ? -v : v;
    endfunction

    function automatic longint div_round(longint num, longint den);
        longint q;
        q = (mag(num) + den / 2) / den;
        return num < 0 ? -q : q;
    endfunction

    function automatic longint shr_round(longint v, int n);
        longint q;
        q = (mag(v) + (longint'(1) << (n - 1))) >>> n;
        return v < 0 ? -q : q;
    endfunction

    function automatic longint isqrt(longint unsigned x);
        longint unsigned r, bitv;
        r = 0;
        bitv = 64'd1 << 62;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        return longint'(r);
    endfunction

    function automatic logic [31:0] sat32(longint v);
        if (v > 64'sd2147483647) v = 64'sd2147483647;
        if (v < -64'sd2147483648) v = -64'sd2147483648;
        return v[31:0];
    endfunction

    // ten vertices of one arrow
    task automatic predict_arrow(input logic [31:0] sp[3], input logic [31:0] ep[3],
                                 input logic fin);
        longint st[3], en[3], d[3], q[3], bv[3], tv[3], toff[3], boff[3], along[3];
        longint s, a, b, c, len, r, v;
        longint unsigned m, g;
        int ex, h;
        vertex_t vx;
        logic [31:0] o[3];
        s = longint'(scale_shadow);
        m = 0;
        for (int i = 0; i < 3; i++) begin
            st[i] = longint'(signed'(sp[i]));
            en[i] = longint'(signed'(ep[i]));
            d[i] = en[i] - st[i];
            along[i] = shr_round(d[i] * s, 16);
            toff[i] = 0;
            boff[i] = 0;
            if (mag(d[i]) > m) m = mag(d[i]);
        end
        if (m != 0) begin
            ex = 0;
            while (m >= (64'd1 << 27)) begin m >>= 1; ex--; end
            while (m < (64'd1 << 26)) begin m <<= 1; ex++; end
            for (int i = 0; i < 3; i++) begin
                g = mag(d[i]);
                g = ex >= 0 ? g << ex : g >> (-ex);
                q[i] = d[i] < 0 ? -longint'(g) : longint'(g);
            end
            a = q[0]; b = q[1]; c = q[2];
            len = isqrt(longint'(a * a + b * b + c * c));
            if (39 * longint'(unsigned'(b * b)) >= 0 &&
                64'd39 * unsigned'(b * b) >= 64'd361 * unsigned'(a * a + c * c)) begin
                r = isqrt(a * a + b * b);
                bv[0] = div_round(len * b, r); bv[1] = div_round(-len * a, r); bv[2] = 0;
                tv[0] = div_round(-a * c, r); tv[1] = div_round(-b * c, r); tv[2] = r;
            end else begin
                r = isqrt(a * a + c * c);
                bv[0] = div_round(-len * c, r); bv[1] = 0; bv[2] = div_round(len * a, r);
                tv[0] = div_round(-a * b, r); tv[1] = r; tv[2] = div_round(-c * b, r);
            end
            for (int i = 0; i < 3; i++) begin
                toff[i] = shr_round(tv[i] * s, 17 + ex);
                boff[i] = shr_round(bv[i] * s, 17 + ex);
            end
        end
        for (int k = 0; k < 10; k++) begin
            for (int i = 0; i < 3; i++) begin
                if (k == 0) v = st[i];
                else if (k % 2 == 1) v = en[i];
                else begin
                    h = (k - 2) / 2;
                    v = en[i] - along[i];
                    case (h)
                        0: v -= toff[i];
                        1: v += toff[i];
                        2: v -= boff[i];
                        default: v += boff[i];
                    endcase
                end
                o[i] = sat32(v);
            end
            vx.x = o[0]; vx.y = o[1]; vx.z = o[2];
            vx.num = 4'(k);
            vx.arrow_done = (4'(k) == VTX_LAST);
            vx.batch_done = (4'(k) == VTX_LAST) && fin;
            vertex_queue = {vertex_queue, vx};
        end
    endtask

    task automatic send_segment(input logic [31:0] sp[3], input logic [31:0] ep[3],
                                input logic fin);
        @(negedge aclk);
        s_valid = 1'b0;
        while (tx_gaps && $urandom_range(99) < 20) @(negedge aclk);
        {s_start_x, s_start_y, s_start_z} = {sp[0], sp[1], sp[2]};
        {s_end_x, s_end_y, s_end_z} = {ep[0], ep[1], ep[2]};
        s_final_segment = fin;
        s_valid = 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_arrow(sp, ep, fin);
    endtask

    task automatic write_reg(input logic [2:0] addr, input logic [31:0] data);
        @(negedge aclk);
        s_valid = 1'b0;
        psel = 1'b1; pwrite = 1'b1; penable = 1'b0; paddr = addr; pwdata = data;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        if (addr == ADDR_HEAD_SCALE) scale_shadow = data[15:0];
        @(negedge aclk);
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    endtask

    task automatic drain;
        @(negedge aclk);
        s_valid = 1'b0;
        while (vertex_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(2097152)) - 1048576);
            2: return 32'($signed($urandom_range(512)) - 256);
            default: return {$urandom_range(1) ? 16'hffff : 16'h0000, 16'($urandom)};
        endcase
    endfunction

    task automatic send_random(int mode);
        logic [31:0] sp[3], ep[3];
        for (int i = 0; i < 3; i++) begin
            sp[i] = rand_coord(mode);
            ep[i] = rand_coord(mode);
        end
        case ($urandom_range(9))
            0: ep = sp;
            1: begin ep[0] = sp[0] + rand_coord(2); ep[2] = sp[2] + rand_coord(2); end
            2: begin ep[0] = sp[0]; ep[1] = sp[1]; end
            default: ;
        endcase
        send_segment(sp, ep, 1'($urandom_range(1)));
    endtask

    task automatic test_directed;
        logic [31:0] mx, mn;
        mx = 32'h7fffffff;
        mn = 32'h80000000;
        send_segment('{0, 0, 0}, '{0, 0, 0}, 1'b0);
        send_segment('{mn, mn, mn}, '{mx, mx, mx}, 1'b1);
        send_segment('{mx, mx, mx}, '{mn, mn, mn}, 1'b0);
        send_segment('{mx, mn, mx}, '{mn, mx, mn}, 1'b1);
        send_segment('{5, 7, 9}, '{5, 7, 9}, 1'b1);
        send_segment('{0, 0, 0}, '{32'h10000, 0, 0}, 1'b0);
        send_segment('{0, 0, 0}, '{0, 32'h10000, 0}, 1'b0);
        send_segment('{0, 0, 0}, '{0, 32'hffff0000, 0}, 1'b0);
        send_segment('{0, 0, 0}, '{0, 0, 32'h10000}, 1'b1);
        send_segment('{0, 0, 0}, '{32'd1, 0, 0}, 1'b0);
        send_segment('{0, 0, 0}, '{32'd1, 32'd3, 32'd1}, 1'b0);
        send_segment('{0, 0, 0}, '{32'd5, 32'd95, 32'd0}, 1'b0);
        send_segment('{0, 0, 0}, '{32'd3122, 32'd9500, 32'd0}, 1'b0);
        send_segment('{32'hffffffff, 0, 0}, '{0, 32'hffffffff, 32'd1}, 1'b1);
        drain();
    endtask

    task automatic test_scale;
        logic [15:0] scales[4];
        scales = '{16'd0, 16'hffff, 16'd1, 16'h8000};
        for (int j = 0; j < 4; j++) begin
            write_reg(ADDR_HEAD_SCALE, {16'($urandom), scales[j]});
            for (int n = 0; n < 8; n++) send_random(n % 4);
            drain();
        end
        write_reg(3'd4, $urandom);
        for (int n = 0; n < 6; n++) send_random(n % 4);
        drain();
    endtask

    task automatic test_random;
        for (int n = 0; n < 240; n++) begin
            if (n % 60 == 0 && n != 0) begin
                drain();
                write_reg(ADDR_HEAD_SCALE, $urandom);
            end
            if (n == 100) begin tx_gaps = 1'b0; rx_gaps = 1'b0; end
            if (n == 150) begin tx_gaps = 1'b1; rx_gaps = 1'b1; end
            send_random($urandom_range(3));
        end
        drain();
    endtask

    task automatic test_backpressure;
        hold_left = 500;
        for (int n = 0; n < 8; n++) send_random($urandom_range(3));
        drain();
        write_reg(ADDR_HEAD_SCALE, HEAD_SCALE_RESET);
        for (int n = 0; n < 4; n++) send_random($urandom_range(3));
        drain();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_directed();
        test_scale();
        test_random();
        test_backpressure();
        if (errors == 0 && vertex_queue.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> arrow_glyph_vertex_generator_top.f
rtl/agv_pkg.sv
rtl/agv_fifo.sv
rtl/agv_geom.sv
rtl/agv_emit.sv
rtl/arrow_glyph_vertex_generator_top.sv
verif/arrow_glyph_vertex_generator_top_tb.sv
